>>> sv/aea_pkg.sv
// ----------------------------------------------------------------------------
// aea_pkg
// Shared types and constants of the auto-exposure adaptation block.
// ----------------------------------------------------------------------------
package aea_pkg;

    // pixels per frame, averaging divisor
    localparam int FRAME_PIXELS = 4;

    localparam int ACC_W      = 26;
    localparam int LUMA_W     = 18;
    localparam int PROD_W     = 24;
    localparam int DIV_W      = 26;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [15:0] EXPO_MAX = 16'hFFFF;

    localparam logic [15:0] TARGET_KEY_RST   = 16'd128;
    localparam logic [15:0] ADAPT_RATE_RST   = 16'd131;
    localparam logic [7:0]  WEIGHT_RED_RST   = 8'd77;
    localparam logic [7:0]  WEIGHT_GREEN_RST = 8'd151;
    localparam logic [7:0]  WEIGHT_BLUE_RST  = 8'd28;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_KEY   = 3'd0,
        CFG_ADAPT_RATE   = 3'd1,
        CFG_WEIGHT_RED   = 3'd2,
        CFG_WEIGHT_GREEN = 3'd3,
        CFG_WEIGHT_BLUE  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] target_key;
        logic [15:0] adapt_rate;
        logic [7:0]  weight_red;
        logic [7:0]  weight_green;
        logic [7:0]  weight_blue;
    } cfg_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [31:0] frame_time_ms;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [15:0] exposure;
        logic        dark_frame;
    } result_t;

    // one finished frame handed from front to back
    typedef struct packed {
        logic [ACC_W-1:0] luma_sum;
        logic [31:0]      frame_time_ms;
    } frame_job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_GOAL,
        BK_FACTOR,
        BK_BLEND,
        BK_FINISH
    } back_state_t;

endpackage

>>> sv/aea_front.sv
// ----------------------------------------------------------------------------
// aea_front
// Pixel front end: weighted luminance per pixel and per-frame accumulation.
// ----------------------------------------------------------------------------
module aea_front (
    input  logic                clk,
    input  logic                rst_n,
    input  aea_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  aea_pkg::pixel_t     in_data,
    output logic                job_valid,
    input  logic                job_ready,
    output aea_pkg::frame_job_t job_data
);
    import aea_pkg::*;

    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic [31:0]       s1_time_reg;
    logic [PROD_W-1:0] pr_reg;
    logic [PROD_W-1:0] pg_reg;
    logic [PROD_W-1:0] pb_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;

    logic              advance;
    logic              take;
    logic [ACC_W-1:0]  wsum;
    logic [LUMA_W-1:0] luma;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;

    // a last pixel waits in stage one until the queue has room
    assign advance  = s1_valid_reg && (!s1_last_reg || job_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign take     = in_valid && in_ready;

    assign wsum    = ACC_W'(pr_reg) + ACC_W'(pg_reg) + ACC_W'(pb_reg);
    assign luma    = wsum[ACC_W-1:8];
    assign acc_sum = {1'b0, acc_reg} + (ACC_W+1)'(luma);
    assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

    assign job_valid              = s1_valid_reg && s1_last_reg;
    assign job_data.luma_sum      = acc_sat;
    assign job_data.frame_time_ms = s1_time_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (advance)
        begin
            acc_next = s1_last_reg ? '0 : acc_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (take)
            begin
                s1_valid_reg <= 1'b1;
                s1_last_reg  <= in_data.last_pixel;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pr_reg      <= PROD_W'(cfg.weight_red)   * PROD_W'(in_data.red);
            pg_reg      <= PROD_W'(cfg.weight_green) * PROD_W'(in_data.green);
            pb_reg      <= PROD_W'(cfg.weight_blue)  * PROD_W'(in_data.blue);
            s1_time_reg <= in_data.frame_time_ms;
        end
    end

endmodule

>>> sv/aea_queue.sv
// ----------------------------------------------------------------------------
// aea_queue
// Short frame queue between the pixel front end and the exposure back end.
// ----------------------------------------------------------------------------
module aea_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  aea_pkg::frame_job_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output aea_pkg::frame_job_t pop_data
);
    import aea_pkg::*;

    frame_job_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/aea_div.sv
// ----------------------------------------------------------------------------
// aea_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aea_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [aea_pkg::DIV_W-1:0] dividend,
    input  logic [aea_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [aea_pkg::DIV_W-1:0] quotient
);
    import aea_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsr_reg;

    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top of quo_reg as quotient bits enter below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

endmodule

>>> sv/aea_back.sv
// ----------------------------------------------------------------------------
// aea_back
// Per-frame back end: average, target exposure, blend factor and update.
// ----------------------------------------------------------------------------
module aea_back (
    input  logic                clk,
    input  logic                rst_n,
    input  aea_pkg::cfg_t       cfg,
    input  logic                job_valid,
    output logic                job_ready,
    input  aea_pkg::frame_job_t job_data,
    output logic                out_valid,
    input  logic                out_ready,
    output aea_pkg::result_t    out_data
);
    import aea_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;

    logic [31:0]      job_time_reg;
    logic [31:0]      job_time_next;
    logic [15:0]      goal_reg;
    logic [15:0]      goal_next;
    logic             dark_reg;
    logic             dark_next;
    logic [16:0]      factor_reg;
    logic [16:0]      factor_next;
    logic [15:0]      diff_reg;
    logic [15:0]      diff_next;
    logic             up_reg;
    logic             up_next;
    logic [32:0]      step_reg;
    logic [32:0]      step_next;
    logic [15:0]      cur_reg;
    logic [15:0]      cur_next;
    logic [31:0]      prev_time_reg;
    logic [31:0]      prev_time_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_data_reg;
    result_t          out_data_next;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quotient;

    logic [ACC_W-1:0] avg;
    logic [31:0]      dt;
    logic [47:0]      rate_prod;
    logic [15:0]      expo;
    logic             out_free;

    aea_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // frame size is a power of two, so the average is a shift
    assign avg       = ACC_W'(job_data.luma_sum / FRAME_PIXELS);
    assign dt        = job_time_reg - prev_time_reg;
    assign rate_prod = 48'(dt) * 48'(cfg.adapt_rate);
    assign expo      = up_reg ? cur_reg + step_reg[31:16] : cur_reg - step_reg[31:16];
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        job_time_next  = job_time_reg;
        goal_next      = goal_reg;
        dark_next      = dark_reg;
        factor_next    = factor_reg;
        diff_next      = diff_reg;
        up_next        = up_reg;
        step_next      = step_reg;
        cur_next       = cur_reg;
        prev_time_next = prev_time_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        job_ready      = 1'b0;
        div_start      = 1'b0;
        div_dividend   = {2'b00, cfg.target_key, 8'h00};
        div_divisor    = DIV_W'(avg);

        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_ready     = 1'b1;
                    job_time_next = job_data.frame_time_ms;
                    if (avg == '0)
                    begin
                        // dark frame: target saturates
                        dark_next  = 1'b1;
                        goal_next  = EXPO_MAX;
                        state_next = BK_FACTOR;
                    end
                    else
                    begin
                        dark_next  = 1'b0;
                        div_start  = 1'b1;
                        state_next = BK_DIV_GOAL;
                    end
                end
            end
            BK_DIV_GOAL:
            begin
                if (div_done)
                begin
                    goal_next  = (div_quotient > DIV_W'(EXPO_MAX)) ? EXPO_MAX
                                                                   : div_quotient[15:0];
                    state_next = BK_FACTOR;
                end
            end
            BK_FACTOR:
            begin
                factor_next = (rate_prod > 48'(ONE_Q16)) ? ONE_Q16 : rate_prod[16:0];
                up_next     = goal_reg >= cur_reg;
                diff_next   = (goal_reg >= cur_reg) ? goal_reg - cur_reg : cur_reg - goal_reg;
                state_next  = BK_BLEND;
            end
            BK_BLEND:
            begin
                step_next  = 33'(factor_reg) * 33'(diff_reg);
                state_next = BK_FINISH;
            end
            BK_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.exposure   = expo;
                    out_data_next.dark_frame = dark_reg;
                    cur_next                 = expo;
                    prev_time_next           = job_time_reg;
                    state_next               = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cur_reg       <= '0;
            prev_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            prev_time_reg <= prev_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_time_reg <= job_time_next;
        goal_reg     <= goal_next;
        dark_reg     <= dark_next;
        factor_reg   <= factor_next;
        diff_reg     <= diff_next;
        up_reg       <= up_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
    end

endmodule

>>> sv/auto_exposure_adapt.sv
// ----------------------------------------------------------------------------
// auto_exposure_adapt
// Auto-exposure adaptation over a small downsampled frame.
// ----------------------------------------------------------------------------
// Pixels (RGB Q8.8) are taken one per clock unless a last pixel waits for room
// in the frame queue; each pixel's weighted products are registered, then its
// luminance is summed into a saturating accumulator. The pixel marked last
// closes the frame and hands its sum and time stamp to a two-entry frame queue,
// so pixel intake continues while earlier frames are worked on. For each frame
// leaving the queue the average is a shift taken on the way in, key / average
// runs on a bit-serial divider, then the blend factor, the blend product and
// the output register are formed in turn, the last held while the output is
// full. A dark frame skips the divider and goes straight to the blend factor.
// The back end returns to idle before taking the next frame. One result per
// frame, held in an output register until taken. Configuration writes take
// effect at once and should be made while no frame is in flight.
module auto_exposure_adapt (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aea_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aea_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  aea_pkg::pixel_t                     in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output aea_pkg::result_t                    out_data
);
    import aea_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;

    logic       fj_valid;
    logic       fj_ready;
    frame_job_t fj_data;
    logic       bj_valid;
    logic       bj_ready;
    frame_job_t bj_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_KEY:   cfg_next.target_key   = cfg_data;
                CFG_ADAPT_RATE:   cfg_next.adapt_rate   = cfg_data;
                CFG_WEIGHT_RED:   cfg_next.weight_red   = cfg_data[7:0];
                CFG_WEIGHT_GREEN: cfg_next.weight_green = cfg_data[7:0];
                CFG_WEIGHT_BLUE:  cfg_next.weight_blue  = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_key   <= TARGET_KEY_RST;
            cfg_reg.adapt_rate   <= ADAPT_RATE_RST;
            cfg_reg.weight_red   <= WEIGHT_RED_RST;
            cfg_reg.weight_green <= WEIGHT_GREEN_RST;
            cfg_reg.weight_blue  <= WEIGHT_BLUE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    aea_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job_data  (fj_data)
    );

    aea_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_data  (fj_data),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_data   (bj_data)
    );

    aea_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job_data  (bj_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
